// ----- rtl/xdec_pkg.sv -----
// Package for the x86-64 subset instruction decoder.
// Holds the item types, the kind codes and the opcode constants.
// No dependencies.
package xdec_pkg;

  // Kind codes of a decoded instruction.
  localparam logic [3:0] KIND_NOP     = 4'd0;
  localparam logic [3:0] KIND_MOVIMM  = 4'd1;
  localparam logic [3:0] KIND_CALL    = 4'd2;
  localparam logic [3:0] KIND_RET     = 4'd3;
  localparam logic [3:0] KIND_SYSCALL = 4'd4;
  localparam logic [3:0] KIND_PUSH    = 4'd5;
  localparam logic [3:0] KIND_POP     = 4'd6;
  localparam logic [3:0] KIND_JMP8    = 4'd7;
  localparam logic [3:0] KIND_JMP32   = 4'd8;
  localparam logic [3:0] KIND_JZ      = 4'd9;
  localparam logic [3:0] KIND_JNZ     = 4'd10;
  localparam logic [3:0] KIND_LEA     = 4'd11;
  localparam logic [3:0] KIND_CMPIMM  = 4'd12;
  localparam logic [3:0] KIND_XOR     = 4'd13;
  localparam logic [3:0] KIND_UNKNOWN = 4'd14;

  // Opcode bytes.
  localparam logic [7:0] OP_ENDBR_0  = 8'hF3;
  localparam logic [7:0] OP_TWO_BYTE = 8'h0F;
  localparam logic [7:0] OP_ENDBR_2  = 8'h1E;
  localparam logic [7:0] OP_ENDBR_3  = 8'hFA;
  localparam logic [7:0] OP_REX_LO   = 8'h40;
  localparam logic [7:0] OP_REX_HI   = 8'h4F;
  localparam logic [7:0] OP_MOV_LO   = 8'hB8;
  localparam logic [7:0] OP_MOV_HI   = 8'hBF;
  localparam logic [7:0] OP_CALL     = 8'hE8;
  localparam logic [7:0] OP_JMP32    = 8'hE9;
  localparam logic [7:0] OP_RET      = 8'hC3;
  localparam logic [7:0] OP_SYSCALL2 = 8'h05;
  localparam logic [7:0] OP_PUSH_LO  = 8'h50;
  localparam logic [7:0] OP_POP_LO   = 8'h58;
  localparam logic [7:0] OP_POP_HI   = 8'h5F;
  localparam logic [7:0] OP_JMP8     = 8'hEB;
  localparam logic [7:0] OP_JZ       = 8'h74;
  localparam logic [7:0] OP_JNZ      = 8'h75;
  localparam logic [7:0] OP_LEA      = 8'h8D;
  localparam logic [7:0] OP_GRP1_I8  = 8'h83;
  localparam logic [7:0] OP_XOR      = 8'h31;

  // ModRM masks for the RIP-relative and CMP forms.
  localparam logic [7:0] MODRM_RIP_MASK = 8'hC7;
  localparam logic [7:0] MODRM_RIP_VAL  = 8'h05;
  localparam logic [7:0] MODRM_REG_MASK = 8'h38;

  // One input item: the byte window and the instruction address.
  typedef struct packed {
    logic [63:0] bytes_low;
    logic [15:0] bytes_high;
    logic [63:0] instr_addr;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic [63:0] immediate;
    logic [3:0]  length;
  } out_item_t;

endpackage

// ----- rtl/xdec_decode.sv -----
// Combinational decode of one instruction window into a result item.
// Depends on xdec_pkg for the item types and the opcode and kind codes.
module xdec_decode (
  input  xdec_pkg::in_item_t  cmd,
  output xdec_pkg::out_item_t result
);

  logic [79:0] win;
  logic [79:0] sw;
  logic        has_rex;
  logic [7:0]  rex;
  logic [7:0]  op;
  logic [7:0]  modrm;
  logic [3:0]  pre_len;
  logic        is_endbr;
  logic [31:0] disp;
  logic [3:0]  len;

  // Window with byte 0 in the low bits; skip the REX byte when there is one.
  assign win     = {cmd.bytes_high, cmd.bytes_low};
  assign has_rex = (win[7:0] >= xdec_pkg::OP_REX_LO) && (win[7:0] <= xdec_pkg::OP_REX_HI);
  assign rex     = has_rex ? win[7:0] : 8'h00;
  assign sw      = has_rex ? {8'h00, win[79:8]} : win;
  assign op      = sw[7:0];
  assign modrm   = sw[15:8];
  assign disp    = sw[47:16];
  assign pre_len = {3'b000, has_rex};

  assign is_endbr = (win[7:0] == xdec_pkg::OP_ENDBR_0) && (win[15:8] == xdec_pkg::OP_TWO_BYTE)
                 && (win[23:16] == xdec_pkg::OP_ENDBR_2) && (win[31:24] == xdec_pkg::OP_ENDBR_3);

  // Opcode classification and field selection.
  always_comb begin
    result.kind       = xdec_pkg::KIND_UNKNOWN;
    result.first_reg  = 4'd0;
    result.second_reg = 4'd0;
    result.immediate  = 64'd0;
    result.length     = 4'd1;
    len               = pre_len + 4'd6;
    if (is_endbr) begin
      result.kind   = xdec_pkg::KIND_NOP;
      result.length = 4'd4;
    end else if (op >= xdec_pkg::OP_MOV_LO && op <= xdec_pkg::OP_MOV_HI) begin
      result.kind      = xdec_pkg::KIND_MOVIMM;
      result.first_reg = {rex[0], op[2:0]};
      if (rex[3]) begin
        result.immediate = sw[71:8];
        result.length    = pre_len + 4'd9;
      end else begin
        result.immediate = {32'd0, sw[39:8]};
        result.length    = pre_len + 4'd5;
      end
    end else if (op == xdec_pkg::OP_CALL || op == xdec_pkg::OP_JMP32) begin
      result.kind      = (op == xdec_pkg::OP_CALL) ? xdec_pkg::KIND_CALL
                                                   : xdec_pkg::KIND_JMP32;
      result.immediate = {32'd0, sw[39:8]};
      result.length    = pre_len + 4'd5;
    end else if (op == xdec_pkg::OP_RET) begin
      result.kind   = xdec_pkg::KIND_RET;
      result.length = pre_len + 4'd1;
    end else if (op == xdec_pkg::OP_TWO_BYTE && modrm == xdec_pkg::OP_SYSCALL2) begin
      result.kind   = xdec_pkg::KIND_SYSCALL;
      result.length = pre_len + 4'd2;
    end else if (op >= xdec_pkg::OP_PUSH_LO && op <= xdec_pkg::OP_POP_HI) begin
      result.kind      = (op < xdec_pkg::OP_POP_LO) ? xdec_pkg::KIND_PUSH
                                                    : xdec_pkg::KIND_POP;
      result.first_reg = {rex[0], op[2:0]};
      result.length    = pre_len + 4'd1;
    end else if (op == xdec_pkg::OP_JMP8 || op == xdec_pkg::OP_JZ
              || op == xdec_pkg::OP_JNZ) begin
      if (op == xdec_pkg::OP_JMP8) begin
        result.kind = xdec_pkg::KIND_JMP8;
      end else if (op == xdec_pkg::OP_JZ) begin
        result.kind = xdec_pkg::KIND_JZ;
      end else begin
        result.kind = xdec_pkg::KIND_JNZ;
      end
      result.immediate = {{56{modrm[7]}}, modrm};
      result.length    = pre_len + 4'd2;
    end else if (op == xdec_pkg::OP_LEA
              && (modrm & xdec_pkg::MODRM_RIP_MASK) == xdec_pkg::MODRM_RIP_VAL) begin
      // Target is the address of the next instruction plus disp32.
      result.kind      = xdec_pkg::KIND_LEA;
      result.first_reg = {rex[2], modrm[5:3]};
      result.length    = len;
      result.immediate = cmd.instr_addr + {60'd0, len} + {{32{disp[31]}}, disp};
    end else if (op == xdec_pkg::OP_GRP1_I8
              && (modrm & xdec_pkg::MODRM_REG_MASK) == xdec_pkg::MODRM_REG_MASK) begin
      result.kind      = xdec_pkg::KIND_CMPIMM;
      result.first_reg = {rex[0], modrm[2:0]};
      result.immediate = {{56{sw[23]}}, sw[23:16]};
      result.length    = pre_len + 4'd3;
    end else if (op == xdec_pkg::OP_XOR) begin
      result.kind       = xdec_pkg::KIND_XOR;
      result.first_reg  = {rex[0], modrm[2:0]};
      result.second_reg = {rex[2], modrm[5:3]};
      result.length     = pre_len + 4'd2;
    end
  end

endmodule

// ----- rtl/x86_64_subset_instruction_decoder.sv -----
// Top level of the x86-64 subset instruction decoder.
// Depends on xdec_pkg and xdec_decode.
//
// Usage:
//   An item (a ten-byte instruction window and its address) is taken on the
//   cmd port at each rising edge where start is high and busy is low. busy
//   is held low, so an item may be offered in every cycle.
//   Each item gives exactly one result item on the result port, marked by a
//   one-cycle done strobe. The receiver has no way to hold results off, and
//   none is needed: results leave at the rate items arrive.
// Datapath and throughput:
//   The item is captured in an input register, decoded by one combinational
//   pass (byte selection and a three-term 64-bit sum for the LEA target), and
//   captured in the result register. done rises at the edge after the one
//   that accepted the item, and the result register is loaded at that edge
//   too. One item per cycle is sustained.
// Reset:
//   rst is synchronous and active high. It drops every item in flight; no
//   done strobe follows for items accepted before or during reset.
module x86_64_subset_instruction_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  xdec_pkg::in_item_t  cmd,
  output logic                done,
  output xdec_pkg::out_item_t result
);

  logic                in_valid;
  xdec_pkg::in_item_t  in_item;
  xdec_pkg::out_item_t dec_item;

  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_item <= cmd;
    end
  end

  xdec_decode u_decode (
    .cmd    (in_item),
    .result (dec_item)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= dec_item;
    end
  end

  // Every result traces back to an accepted item, with no reset in between.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start, 2) && !$past(rst, 2) && !$past(rst, 1)))
    else $error("done without an accepted item");

  // Lengths stay within the ten-byte window.
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.length >= 4'd1 && result.length <= 4'd10))
    else $error("result length out of range");

  // Unknown instructions consume one byte.
  a_unknown_len: assert property (@(posedge clk) disable iff (rst)
    (done && result.kind == xdec_pkg::KIND_UNKNOWN) |-> (result.length == 4'd1))
    else $error("unknown instruction with length other than one");

  // Only XOR carries a second register.
  a_second_reg: assert property (@(posedge clk) disable iff (rst)
    (done && result.second_reg != 4'd0) |-> (result.kind == xdec_pkg::KIND_XOR))
    else $error("second register set on a non-XOR result");

endmodule

// ----- sim/tb_x86_64_subset_instruction_decoder.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the x86-64 subset instruction decoder.
// Depends on xdec_pkg and the x86_64_subset_instruction_decoder RTL.
module tb_x86_64_subset_instruction_decoder;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 6;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  xdec_pkg::in_item_t  cmd;
  logic                done;
  xdec_pkg::out_item_t result;

  // Decodes that have been issued and whose result has not come back yet.
  xdec_pkg::out_item_t pending_decodes[$];
  xdec_pkg::out_item_t expected_decode;
  int                  mismatch_count = 0;
  int                  cycle_count = 0;
  int                  idle_pct;

  x86_64_subset_instruction_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decodes one ten-byte window the way the block should.
  function automatic xdec_pkg::out_item_t decode_window(xdec_pkg::in_item_t w);
    logic [79:0]         win;
    logic [7:0]          rex_byte;
    logic [7:0]          opc;
    logic [7:0]          modrm;
    logic [31:0]         disp;
    int unsigned         p;
    xdec_pkg::out_item_t r;
    win      = {w.bytes_high, w.bytes_low};
    r        = '0;
    r.kind   = xdec_pkg::KIND_UNKNOWN;
    r.length = 4'd1;
    rex_byte = 8'h00;
    p        = 0;
    if (win[7:0] == xdec_pkg::OP_ENDBR_0 && win[15:8] == xdec_pkg::OP_TWO_BYTE &&
        win[23:16] == xdec_pkg::OP_ENDBR_2 && win[31:24] == xdec_pkg::OP_ENDBR_3) begin
      r.kind   = xdec_pkg::KIND_NOP;
      r.length = 4'd4;
    end else begin
      opc = win[7:0];
      // A single REX prefix shifts the opcode to byte 1.
      if (opc >= xdec_pkg::OP_REX_LO && opc <= xdec_pkg::OP_REX_HI) begin
        rex_byte = opc;
        p        = 1;
        opc      = win[15:8];
      end
      modrm = win[8*(p+1) +: 8];
      if (opc >= xdec_pkg::OP_MOV_LO && opc <= xdec_pkg::OP_MOV_HI) begin
        r.kind      = xdec_pkg::KIND_MOVIMM;
        r.first_reg = {rex_byte[0], opc[2:0]};
        if (rex_byte[3]) begin
          r.immediate = win[8*(p+1) +: 64];
          r.length    = 4'(p + 9);
        end else begin
          r.immediate = {32'h0, win[8*(p+1) +: 32]};
          r.length    = 4'(p + 5);
        end
      end else if (opc == xdec_pkg::OP_CALL || opc == xdec_pkg::OP_JMP32) begin
        r.kind      = (opc == xdec_pkg::OP_CALL) ? xdec_pkg::KIND_CALL
                                                 : xdec_pkg::KIND_JMP32;
        r.immediate = {32'h0, win[8*(p+1) +: 32]};
        r.length    = 4'(p + 5);
      end else if (opc == xdec_pkg::OP_RET) begin
        r.kind   = xdec_pkg::KIND_RET;
        r.length = 4'(p + 1);
      end else if (opc == xdec_pkg::OP_TWO_BYTE && modrm == xdec_pkg::OP_SYSCALL2) begin
        r.kind   = xdec_pkg::KIND_SYSCALL;
        r.length = 4'(p + 2);
      end else if (opc >= xdec_pkg::OP_PUSH_LO && opc <= xdec_pkg::OP_POP_HI) begin
        r.kind      = (opc < xdec_pkg::OP_POP_LO) ? xdec_pkg::KIND_PUSH
                                                  : xdec_pkg::KIND_POP;
        r.first_reg = {rex_byte[0], opc[2:0]};
        r.length    = 4'(p + 1);
      end else if (opc == xdec_pkg::OP_JMP8 || opc == xdec_pkg::OP_JZ
                || opc == xdec_pkg::OP_JNZ) begin
        if (opc == xdec_pkg::OP_JMP8) begin
          r.kind = xdec_pkg::KIND_JMP8;
        end else if (opc == xdec_pkg::OP_JZ) begin
          r.kind = xdec_pkg::KIND_JZ;
        end else begin
          r.kind = xdec_pkg::KIND_JNZ;
        end
        r.immediate = {{56{modrm[7]}}, modrm};
        r.length    = 4'(p + 2);
      end else if (opc == xdec_pkg::OP_LEA
                && (modrm & xdec_pkg::MODRM_RIP_MASK) == xdec_pkg::MODRM_RIP_VAL) begin
        // The target is taken from the end of the instruction.
        disp        = win[8*(p+2) +: 32];
        r.kind      = xdec_pkg::KIND_LEA;
        r.first_reg = {rex_byte[2], modrm[5:3]};
        r.length    = 4'(p + 6);
        r.immediate = w.instr_addr + 64'(p + 6) + {{32{disp[31]}}, disp};
      end else if (opc == xdec_pkg::OP_GRP1_I8
                && (modrm & xdec_pkg::MODRM_REG_MASK) == xdec_pkg::MODRM_REG_MASK) begin
        r.kind      = xdec_pkg::KIND_CMPIMM;
        r.first_reg = {rex_byte[0], modrm[2:0]};
        r.immediate = {{56{win[8*(p+2)+7]}}, win[8*(p+2) +: 8]};
        r.length    = 4'(p + 3);
      end else if (opc == xdec_pkg::OP_XOR) begin
        r.kind       = xdec_pkg::KIND_XOR;
        r.first_reg  = {rex_byte[0], modrm[2:0]};
        r.second_reg = {rex_byte[2], modrm[5:3]};
        r.length     = 4'(p + 2);
      end
    end
    return r;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offers one item, with random idle cycles ahead of it, and records its decode.
  task automatic send_window(xdec_pkg::in_item_t w);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
    pending_decodes.push_back(decode_window(w));
  endtask

  // Sends the low n bytes of code; the bytes above them are random filler.
  task automatic send_instr(logic [79:0] code, int n, logic [63:0] addr);
    logic [95:0]        filler;
    logic [79:0]        keep;
    xdec_pkg::in_item_t w;
    filler       = {$urandom, $urandom, $urandom};
    keep         = (n >= 10) ? '1 : ((80'd1 << (8 * n)) - 80'd1);
    code         = (code & keep) | (filler[79:0] & ~keep);
    w.bytes_low  = code[63:0];
    w.bytes_high = code[79:64];
    w.instr_addr = addr;
    send_window(w);
  endtask

  // Holds start low until every issued decode has come back.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  // Random address, now and then close to the top so the LEA add wraps.
  function automatic logic [63:0] random_addr();
    logic [63:0] a;
    a = {$urandom, $urandom};
    if ($urandom_range(7) == 0) a = '1 - 64'($urandom_range(15));
    return a;
  endfunction

  // One random item: mostly well-formed encodings with random content,
  // the rest malformed forms and raw noise.
  task automatic send_random_instr();
    logic [79:0] code;
    logic [7:0]  rex_byte;
    int          pos;
    int          pick;
    code     = '0;
    pos      = 0;
    rex_byte = xdec_pkg::OP_REX_LO | 8'($urandom_range(15));
    pick     = $urandom_range(9);
    if (pick < 2) begin
      // Raw noise over the whole window.
      send_instr(code, 0, random_addr());
    end else if (pick == 2) begin
      // Forms that must decode as unknown or come close to a valid one.
      case ($urandom_range(4))
        0: code[15:0] = {8'($urandom), xdec_pkg::OP_LEA};
        1: code[15:0] = {8'($urandom), xdec_pkg::OP_GRP1_I8};
        2: code[15:0] = {xdec_pkg::OP_REX_LO | 8'($urandom_range(15)), rex_byte};
        3: code[15:0] = {8'($urandom), xdec_pkg::OP_TWO_BYTE};
        default: code[31:0] = {8'($urandom), xdec_pkg::OP_ENDBR_2,
                               xdec_pkg::OP_TWO_BYTE, xdec_pkg::OP_ENDBR_0};
      endcase
      send_instr(code, 4, random_addr());
    end else begin
      if ($urandom_range(1) == 1) begin
        code[7:0] = rex_byte;
        pos = 1;
      end
      case ($urandom_range(13))
        0: begin
          code[31:0] = {xdec_pkg::OP_ENDBR_3, xdec_pkg::OP_ENDBR_2,
                        xdec_pkg::OP_TWO_BYTE, xdec_pkg::OP_ENDBR_0};
          pos = 4;
        end
        1: begin
          code[8*pos +: 8] = xdec_pkg::OP_MOV_LO | 8'($urandom_range(7));
          pos++;
        end
        2: begin
          code[8*pos +: 8] = xdec_pkg::OP_CALL;
          pos++;
        end
        3: begin
          code[8*pos +: 8] = xdec_pkg::OP_JMP32;
          pos++;
        end
        4: begin
          code[8*pos +: 8] = xdec_pkg::OP_RET;
          pos++;
        end
        5: begin
          code[8*pos +: 16] = {xdec_pkg::OP_SYSCALL2, xdec_pkg::OP_TWO_BYTE};
          pos += 2;
        end
        6: begin
          code[8*pos +: 8] = xdec_pkg::OP_PUSH_LO | 8'($urandom_range(7));
          pos++;
        end
        7: begin
          code[8*pos +: 8] = xdec_pkg::OP_POP_LO | 8'($urandom_range(7));
          pos++;
        end
        8: begin
          code[8*pos +: 8] = xdec_pkg::OP_JMP8;
          pos++;
        end
        9: begin
          code[8*pos +: 8] = xdec_pkg::OP_JZ;
          pos++;
        end
        10: begin
          code[8*pos +: 8] = xdec_pkg::OP_JNZ;
          pos++;
        end
        11: begin
          code[8*pos +: 16] = {2'b00, 3'($urandom_range(7)), 3'b101, xdec_pkg::OP_LEA};
          pos += 2;
        end
        12: begin
          code[8*pos +: 16] = {2'($urandom_range(3)), 3'b111, 3'($urandom_range(7)),
                               xdec_pkg::OP_GRP1_I8};
          pos += 2;
        end
        default: begin
          code[8*pos +: 8] = xdec_pkg::OP_XOR;
          pos++;
        end
      endcase
      send_instr(code, pos, random_addr());
    end
  endtask

  // Extremes of every field, every kind and every unknown form.
  task automatic test_directed_encodings();
    idle_pct = 0;
    send_instr(80'hFA1E0FF3, 4, 64'h0);
    send_instr(80'hFB1E0FF3, 4, 64'h0);
    send_instr(80'hFA1E0FF340, 5, 64'h0);
    send_instr(80'hFFFFFFFFB8, 5, 64'h1000);
    send_instr(80'hFFFF_FFFF_FFFF_FFFF_BF49, 10, 64'h1000);
    send_instr(80'h8000_0000_0000_0001_B848, 10, 64'h1000);
    send_instr(80'h80000000E8, 5, 64'h1000);
    send_instr(80'h12345678E9, 5, 64'h1000);
    send_instr(80'hC341, 2, 64'h0);
    send_instr(80'h050F, 2, 64'h0);
    send_instr(80'h0B0F, 2, 64'h0);
    send_instr(80'h5741, 2, 64'h0);
    send_instr(80'h5F41, 2, 64'h0);
    send_instr(80'hFEEB, 2, 64'h0);
    send_instr(80'h7F74, 2, 64'h0);
    send_instr(80'h8075, 2, 64'h0);
    // RIP-relative LEA whose target wraps past the top of the address space.
    send_instr(80'h800000003D8D4C, 7, '1);
    send_instr(80'h7FFFFFFF058D, 6, 64'h0);
    send_instr(80'hC08D, 2, 64'h0);
    send_instr(80'h458D, 2, 64'h0);
    send_instr(80'h80F98341, 4, 64'h0);
    send_instr(80'h05C083, 3, 64'h0);
    send_instr(80'hFF314D, 3, 64'h0);
    send_instr(80'h4048, 2, 64'h0);
    send_instr(80'h90, 1, 64'h0);
    send_instr(80'h0, 10, 64'h0);
    send_instr('1, 10, '1);
    wait_drained();
  endtask

  // Random items offered in every cycle.
  task automatic test_random_back_to_back();
    idle_pct = 0;
    repeat (220) send_random_instr();
    wait_drained();
  endtask

  // Random items with the sender idle most of the time.
  task automatic test_random_sparse_sender();
    idle_pct = 67;
    repeat (215) send_random_instr();
    wait_drained();
  endtask

  // Random items with occasional sender gaps.
  task automatic test_random_light_gaps();
    idle_pct = 22;
    repeat (215) send_random_instr();
    wait_drained();
  endtask

  // Compares each result with the oldest outstanding decode.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("unexpected result, kind", 64'(result.kind),
                        64'(xdec_pkg::KIND_UNKNOWN));
      end else begin
        expected_decode = pending_decodes.pop_front();
        if (result.kind !== expected_decode.kind)
          report_mismatch("kind", 64'(result.kind), 64'(expected_decode.kind));
        if (result.first_reg !== expected_decode.first_reg)
          report_mismatch("first_reg", 64'(result.first_reg), 64'(expected_decode.first_reg));
        if (result.second_reg !== expected_decode.second_reg)
          report_mismatch("second_reg", 64'(result.second_reg),
                          64'(expected_decode.second_reg));
        if (result.immediate !== expected_decode.immediate)
          report_mismatch("immediate", result.immediate, expected_decode.immediate);
        if (result.length !== expected_decode.length)
          report_mismatch("length", 64'(result.length), 64'(expected_decode.length));
      end
    end
  end

  // Ends a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** x86_64_subset_instruction_decoder: FAILED **");
      $finish;
    end
  end

  // Reset, then the tests in turn.
  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    start          = 1'b0;
    cmd            = '0;
    idle_pct       = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_encodings();
    test_random_back_to_back();
    test_random_sparse_sender();
    test_random_light_gaps();

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** x86_64_subset_instruction_decoder: PASSED **");
    end else begin
      $display("** x86_64_subset_instruction_decoder: FAILED **");
    end
    $finish;
  end

endmodule
